// ----- sv/scs_pkg.sv -----
// ----------------------------------------------------------------------------
// scs_pkg
// Shared constants, types and address helpers for the supersequence core.
// ----------------------------------------------------------------------------
package scs_pkg;

	localparam int MAX_LEN   = 32;
	localparam int CHAR_W    = 8;
	localparam int VAL_W     = 6;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int TBL_SIDE  = MAX_LEN + 1;
	localparam int TBL_DEPTH = TBL_SIDE * TBL_SIDE;
	localparam int TBL_AW    = $clog2(TBL_DEPTH);
	localparam int REV_DEPTH = 2 * MAX_LEN;
	localparam int REV_AW    = $clog2(REV_DEPTH);
	localparam int CNT_W     = $clog2(REV_DEPTH + 1);

	localparam logic MODE_FIRST  = 1'b0;
	localparam logic MODE_SECOND = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FILL,
		ST_FILL_END,
		ST_TR_RD,
		ST_TR_UP,
		ST_TR_DEC,
		ST_TL_RD,
		ST_TL_PUSH,
		ST_EMIT_RD,
		ST_EMIT_LD,
		ST_EMPTY
	} scs_state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] first_addr;
		logic [ADDR_W-1:0] second_addr;
		logic [TBL_AW-1:0] tbl_addr;
	} scs_fill_rd_t;

	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] addr;
		logic [VAL_W-1:0]  data;
	} scs_tbl_wr_t;

	function automatic logic [TBL_AW-1:0] cell_addr(input logic [LEN_W-1:0] r,
		input logic [LEN_W-1:0] c);
		cell_addr = TBL_AW'(r) * TBL_AW'(TBL_SIDE) + TBL_AW'(c);
	endfunction

	function automatic logic [ADDR_W-1:0] str_addr(input logic [LEN_W-1:0] n);
		logic [LEN_W-1:0] m;
		m = n - LEN_W'(1);
		str_addr = m[ADDR_W-1:0];
	endfunction

endpackage

// ----- sv/scs_ram.sv -----
// ----------------------------------------------------------------------------
// scs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/scs_fill.sv -----
// ----------------------------------------------------------------------------
// scs_fill
// Two-stage table fill datapath: issue reads for one cell per cycle, then
// compute the cell from diag, up and left and write it back.
// ----------------------------------------------------------------------------
module scs_fill import scs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue,
	input  logic [LEN_W-1:0]   row,
	input  logic [LEN_W-1:0]   col,
	input  logic [CHAR_W-1:0]  a_char,
	input  logic [CHAR_W-1:0]  b_char,
	input  logic [VAL_W-1:0]   tbl_rdata,
	output scs_fill_rd_t       rd,
	output scs_tbl_wr_t        wr
);

	logic              vld_s1;
	logic              top_s1;
	logic              first_col_s1;
	logic [TBL_AW-1:0] waddr_s1;
	logic              fwd_s1;
	logic [VAL_W-1:0]  fwd_val_s1;
	logic [VAL_W-1:0]  left_q;
	logic [VAL_W-1:0]  diag_q;

	logic [VAL_W-1:0]  up;
	logic [VAL_W-1:0]  left;
	logic [VAL_W-1:0]  diag;
	logic [VAL_W-1:0]  val;

	always_comb begin
		rd.first_addr  = str_addr(row);
		rd.second_addr = str_addr(col);
		rd.tbl_addr    = cell_addr(row - LEN_W'(1), col);
	end

	always_comb begin
		if (top_s1) begin
			up = '0;
		end else if (fwd_s1) begin
			up = fwd_val_s1;
		end else begin
			up = tbl_rdata;
		end
		left = first_col_s1 ? '0 : left_q;
		diag = first_col_s1 ? '0 : diag_q;
		if (a_char == b_char) begin
			val = diag + VAL_W'(1);
		end else begin
			val = (up >= left) ? up : left;
		end
	end

	assign wr.we   = vld_s1;
	assign wr.addr = waddr_s1;
	assign wr.data = val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			top_s1       <= (row == LEN_W'(1));
			first_col_s1 <= (col == LEN_W'(1));
			waddr_s1     <= cell_addr(row, col);
			fwd_s1       <= vld_s1 && (waddr_s1 == rd.tbl_addr);
			fwd_val_s1   <= val;
		end
		if (vld_s1) begin
			left_q <= val;
			diag_q <= up;
		end
	end

endmodule

// ----- sv/shortest_common_supersequence_core.sv -----
// ----------------------------------------------------------------------------
// shortest_common_supersequence_core
// Loads two byte strings, fills an LCS table and streams out the shortest
// common supersequence in forward order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one byte of the first (mode 0) or second (mode 1) string.
//   has_char low marks a beat without a byte, e.g. an empty string end.
//   Load beats are taken while in_ready is high, which is only while the core is idle.
//   The beat with mode 1 and end_of_string starts a run on both stored strings.
//   A run fills the table one cell at a time, then walks the traceback
//   steps and pushes the leftover bytes of either string, then reads
//   out the output beats.
//   The single read port of the table memory sets the traceback pace.
//   Bytes past MAX_LEN per string are dropped; overflow is set on every beat
//   of that run. An empty supersequence gives one beat with none high.
//   Output beats sit in a register; while the receiver stalls, the core holds.
//   After the last beat is registered, new load beats are taken again.
//   Reset clears lengths, the overflow flag and all control; memories keep
//   no reset and are written before they are read.
// ----------------------------------------------------------------------------
module shortest_common_supersequence_core import scs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [CHAR_W-1:0] char_value,
	input  logic              has_char,
	input  logic              end_of_string,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_of_run,
	output logic              none,
	output logic              overflow
);

	scs_state_t        state_q, state_d;
	logic [LEN_W-1:0]  len1_q, len2_q, n1_q, n2_q, r_q, c_q, fr_q, fc_q;
	logic              trunc_q, ovf_q;
	logic [CNT_W-1:0]  cnt_q, k_q;
	logic [VAL_W-1:0]  up_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              last_q, none_q, ovf_out_q;

	logic              acc, trigger, slot_free, out_load;
	logic              len1_room, len2_room;
	logic [LEN_W-1:0]  len1_nx, len2_nx;
	logic              trunc_nx;

	logic              first_we, second_we;
	logic [ADDR_W-1:0] first_waddr, second_waddr;
	logic              first_re, second_re, tbl_re, rev_we, rev_re;
	logic [ADDR_W-1:0] first_raddr, second_raddr;
	logic [TBL_AW-1:0] tbl_raddr;
	logic [REV_AW-1:0] rev_waddr, rev_raddr;
	logic [CHAR_W-1:0] rev_wdata;
	logic [CHAR_W-1:0] first_rdata, second_rdata, rev_rdata;
	logic [VAL_W-1:0]  tbl_rdata;
	logic [CNT_W-1:0]  emit_idx;

	logic              fill_issue;
	scs_fill_rd_t      fill_rd;
	scs_tbl_wr_t       fill_wr;

	logic              chars_eq, take_up;
	logic [VAL_W-1:0]  left_v;

	// load path
	assign acc       = in_valid && in_ready;
	assign len1_room = len1_q < LEN_W'(MAX_LEN);
	assign len2_room = len2_q < LEN_W'(MAX_LEN);
	assign first_we  = acc && has_char && (mode == MODE_FIRST) && len1_room;
	assign second_we = acc && has_char && (mode == MODE_SECOND) && len2_room;
	assign first_waddr  = len1_q[ADDR_W-1:0];
	assign second_waddr = len2_q[ADDR_W-1:0];
	assign len1_nx   = len1_q + LEN_W'(first_we);
	assign len2_nx   = len2_q + LEN_W'(second_we);
	assign trunc_nx  = trunc_q || (acc && has_char &&
		(((mode == MODE_FIRST) && !len1_room) || ((mode == MODE_SECOND) && !len2_room)));
	assign trigger   = acc && (mode == MODE_SECOND) && end_of_string;

	assign slot_free = !out_valid_q || out_ready;
	assign fill_issue = (state_q == ST_FILL);

	// traceback decision
	assign chars_eq = (first_rdata == second_rdata);
	assign left_v   = (c_q == LEN_W'(1)) ? '0 : tbl_rdata;
	assign take_up  = (up_q >= left_v);
	assign emit_idx = cnt_q - CNT_W'(1) - k_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (trigger) begin
					state_d = (len1_nx != '0 && len2_nx != '0) ? ST_FILL : ST_TR_RD;
				end
			end
			ST_FILL: begin
				if (fr_q == n1_q && fc_q == n2_q) begin
					state_d = ST_FILL_END;
				end
			end
			ST_FILL_END: state_d = ST_TR_RD;
			ST_TR_RD: begin
				state_d = (r_q == '0 || c_q == '0) ? ST_TL_RD : ST_TR_UP;
			end
			ST_TR_UP: state_d = ST_TR_DEC;
			ST_TR_DEC: state_d = ST_TR_RD;
			ST_TL_RD: begin
				if (r_q != '0 || c_q != '0) begin
					state_d = ST_TL_PUSH;
				end else if (cnt_q == '0) begin
					state_d = ST_EMPTY;
				end else begin
					state_d = ST_EMIT_RD;
				end
			end
			ST_TL_PUSH: state_d = ST_TL_RD;
			ST_EMIT_RD: state_d = ST_EMIT_LD;
			ST_EMIT_LD: begin
				if (slot_free) begin
					state_d = (k_q == cnt_q - CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
				end
			end
			ST_EMPTY: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		first_re     = 1'b0;
		second_re    = 1'b0;
		tbl_re       = 1'b0;
		rev_we       = 1'b0;
		rev_re       = 1'b0;
		out_load     = 1'b0;
		first_raddr  = str_addr(r_q);
		second_raddr = str_addr(c_q);
		tbl_raddr    = cell_addr(r_q - LEN_W'(1), c_q);
		rev_waddr    = cnt_q[REV_AW-1:0];
		rev_wdata    = first_rdata;
		rev_raddr    = emit_idx[REV_AW-1:0];
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_FILL: begin
				first_re     = 1'b1;
				second_re    = 1'b1;
				tbl_re       = 1'b1;
				first_raddr  = fill_rd.first_addr;
				second_raddr = fill_rd.second_addr;
				tbl_raddr    = fill_rd.tbl_addr;
			end
			ST_TR_RD: begin
				if (r_q != '0 && c_q != '0) begin
					first_re  = 1'b1;
					second_re = 1'b1;
					tbl_re    = 1'b1;
				end
			end
			ST_TR_UP: begin
				tbl_re    = 1'b1;
				tbl_raddr = cell_addr(r_q, c_q - LEN_W'(1));
			end
			ST_TR_DEC: begin
				rev_we    = 1'b1;
				rev_wdata = (chars_eq || take_up) ? first_rdata : second_rdata;
			end
			ST_TL_RD: begin
				if (r_q != '0) begin
					first_re = 1'b1;
				end else if (c_q != '0) begin
					second_re = 1'b1;
				end
			end
			ST_TL_PUSH: begin
				rev_we    = 1'b1;
				rev_wdata = (r_q != '0) ? first_rdata : second_rdata;
			end
			ST_EMIT_RD: rev_re = 1'b1;
			ST_EMIT_LD: out_load = slot_free;
			ST_EMPTY: out_load = slot_free;
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len1_q      <= '0;
			len2_q      <= '0;
			trunc_q     <= 1'b0;
			n1_q        <= '0;
			n2_q        <= '0;
			r_q         <= '0;
			c_q         <= '0;
			fr_q        <= '0;
			fc_q        <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (trigger) begin
				n1_q    <= len1_nx;
				n2_q    <= len2_nx;
				r_q     <= len1_nx;
				c_q     <= len2_nx;
				fr_q    <= LEN_W'(1);
				fc_q    <= LEN_W'(1);
				cnt_q   <= '0;
				k_q     <= '0;
				ovf_q   <= trunc_nx;
				len1_q  <= '0;
				len2_q  <= '0;
				trunc_q <= 1'b0;
			end else if (acc) begin
				len1_q  <= len1_nx;
				len2_q  <= len2_nx;
				trunc_q <= trunc_nx;
			end
			if (fill_issue) begin
				if (fc_q == n2_q) begin
					fc_q <= LEN_W'(1);
					fr_q <= fr_q + LEN_W'(1);
				end else begin
					fc_q <= fc_q + LEN_W'(1);
				end
			end
			if (state_q == ST_TR_DEC) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (chars_eq) begin
					r_q <= r_q - LEN_W'(1);
					c_q <= c_q - LEN_W'(1);
				end else if (take_up) begin
					r_q <= r_q - LEN_W'(1);
				end else begin
					c_q <= c_q - LEN_W'(1);
				end
			end
			if (state_q == ST_TL_PUSH) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (r_q != '0) begin
					r_q <= r_q - LEN_W'(1);
				end else begin
					c_q <= c_q - LEN_W'(1);
				end
			end
			if (out_load && state_q == ST_EMIT_LD) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TR_UP) begin
			up_q <= (r_q == LEN_W'(1)) ? '0 : tbl_rdata;
		end
		if (out_load) begin
			ovf_out_q <= ovf_q;
			if (state_q == ST_EMPTY) begin
				out_char_q <= '0;
				last_q     <= 1'b1;
				none_q     <= 1'b1;
			end else begin
				out_char_q <= rev_rdata;
				last_q     <= (k_q == cnt_q - CNT_W'(1));
				none_q     <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign last_of_run = last_q;
	assign none        = none_q;
	assign overflow    = ovf_out_q;

	scs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_first_ram (
		.clk   (clk),
		.we    (first_we),
		.waddr (first_waddr),
		.wdata (char_value),
		.re    (first_re),
		.raddr (first_raddr),
		.rdata (first_rdata)
	);

	scs_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_second_ram (
		.clk   (clk),
		.we    (second_we),
		.waddr (second_waddr),
		.wdata (char_value),
		.re    (second_re),
		.raddr (second_raddr),
		.rdata (second_rdata)
	);

	scs_ram #(.WIDTH(VAL_W), .DEPTH(TBL_DEPTH)) u_tbl_ram (
		.clk   (clk),
		.we    (fill_wr.we),
		.waddr (fill_wr.addr),
		.wdata (fill_wr.data),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	scs_ram #(.WIDTH(CHAR_W), .DEPTH(REV_DEPTH)) u_rev_ram (
		.clk   (clk),
		.we    (rev_we),
		.waddr (rev_waddr),
		.wdata (rev_wdata),
		.re    (rev_re),
		.raddr (rev_raddr),
		.rdata (rev_rdata)
	);

	scs_fill u_fill (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (fill_issue),
		.row       (fr_q),
		.col       (fc_q),
		.a_char    (first_rdata),
		.b_char    (second_rdata),
		.tbl_rdata (tbl_rdata),
		.rd        (fill_rd),
		.wr        (fill_wr)
	);

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len1_q <= LEN_W'(MAX_LEN)) && (len2_q <= LEN_W'(MAX_LEN)))
		else $error("string length beyond capacity");

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (fr_q != '0 && fc_q != '0 && fr_q <= n1_q && fc_q <= n2_q))
		else $error("fill cell out of range");

	a_trace_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TR_DEC) |-> (r_q != '0 && c_q != '0))
		else $error("traceback step on table edge");

	a_rev_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rev_we |-> (cnt_q < CNT_W'(REV_DEPTH)))
		else $error("reverse buffer overrun");

	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_LD) |-> (k_q < cnt_q))
		else $error("emit index past collected bytes");
`endif

endmodule

// ----- test/shortest_common_supersequence_core_tb.sv -----
// ----------------------------------------------------------------------------
// shortest_common_supersequence_core_tb
// Streams string pairs into the core through a bursty sender and drains the
// supersequence through a stalling receiver. Every accepted input beat goes
// through a local LCS-based predictor, and each output beat is checked field
// by field against the oldest predicted beat. Stimulus covers empty strings,
// zero and all-ones bytes, strings out of order, full and truncated strings,
// and random noise.
// ----------------------------------------------------------------------------
module shortest_common_supersequence_core_tb;
	import scs_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int TARGET_BEATS = 150;

	typedef struct packed {
		logic              mode;
		logic [CHAR_W-1:0] ch;
		logic              has;
		logic              eos;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              none;
		logic              ovf;
	} scs_beat_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              mode = MODE_FIRST;
	logic [CHAR_W-1:0] char_value = '0;
	logic              has_char = 1'b0;
	logic              end_of_string = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [CHAR_W-1:0] out_char;
	logic              last_of_run;
	logic              none;
	logic              overflow;

	in_beat_t  pending_beats[$];
	scs_beat_t expected_scs[$];

	logic [CHAR_W-1:0] first_chars [MAX_LEN];
	logic [CHAR_W-1:0] second_chars[MAX_LEN];
	logic [LEN_W-1:0]  first_len = '0;
	logic [LEN_W-1:0]  second_len = '0;
	logic              trunc_seen = 1'b0;

	int errors = 0;
	int cycles = 0;

	shortest_common_supersequence_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.char_value   (char_value),
		.has_char     (has_char),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_char     (out_char),
		.last_of_run  (last_of_run),
		.none         (none),
		.overflow     (overflow)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic void predict_beat(in_beat_t b);
		logic [VAL_W-1:0]  tbl[TBL_SIDE][TBL_SIDE];
		logic [CHAR_W-1:0] rev[REV_DEPTH];
		int n1, n2, r, c, cnt;
		scs_beat_t e;
		if (b.has) begin
			if (b.mode == MODE_FIRST) begin
				if (first_len < MAX_LEN) begin
					first_chars[first_len[ADDR_W-1:0]] = b.ch;
					first_len++;
				end else begin
					trunc_seen = 1'b1;
				end
			end else begin
				if (second_len < MAX_LEN) begin
					second_chars[second_len[ADDR_W-1:0]] = b.ch;
					second_len++;
				end else begin
					trunc_seen = 1'b1;
				end
			end
		end
		if (!b.eos || b.mode == MODE_FIRST)
			return;
		n1 = first_len;
		n2 = second_len;
		for (r = 0; r <= n1; r++) begin
			for (c = 0; c <= n2; c++) begin
				if (r == 0 || c == 0)
					tbl[r][c] = '0;
				else if (first_chars[r-1] == second_chars[c-1])
					tbl[r][c] = tbl[r-1][c-1] + 1'b1;
				else
					tbl[r][c] = (tbl[r-1][c] >= tbl[r][c-1]) ? tbl[r-1][c] : tbl[r][c-1];
			end
		end
		r = n1;
		c = n2;
		cnt = 0;
		while (r > 0 && c > 0) begin
			if (first_chars[r-1] == second_chars[c-1]) begin
				rev[cnt] = first_chars[r-1];
				cnt++;
				r--;
				c--;
			end else if (tbl[r-1][c] >= tbl[r][c-1]) begin
				rev[cnt] = first_chars[r-1];
				cnt++;
				r--;
			end else begin
				rev[cnt] = second_chars[c-1];
				cnt++;
				c--;
			end
		end
		while (r > 0) begin
			rev[cnt] = first_chars[r-1];
			cnt++;
			r--;
		end
		while (c > 0) begin
			rev[cnt] = second_chars[c-1];
			cnt++;
			c--;
		end
		if (cnt == 0) begin
			e = '{ch: '0, last: 1'b1, none: 1'b1, ovf: trunc_seen};
			expected_scs.insert(expected_scs.size(), e);
		end else begin
			for (int k = 0; k < cnt; k++) begin
				e = '{ch: rev[cnt-1-k], last: (k == cnt - 1), none: 1'b0, ovf: trunc_seen};
				expected_scs.insert(expected_scs.size(), e);
			end
		end
		first_len = '0;
		second_len = '0;
		trunc_seen = 1'b0;
	endfunction

	// sender: bursts of beats with random gaps
	in_beat_t head;
	int       gap_left;
	int       burst_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
			burst_left = 1;
		end else begin
			if (in_valid && in_ready) begin
				head = pending_beats.pop_front();
				predict_beat(head);
			end
			if (in_valid && !in_ready) begin
				// hold
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				in_valid <= 1'b1;
				mode <= pending_beats[0].mode;
				char_value <= pending_beats[0].ch;
				has_char <= pending_beats[0].has;
				end_of_string <= pending_beats[0].eos;
				if (burst_left <= 1) begin
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					burst_left = $urandom_range(1, 24);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: changing stall styles, rare holds and one long hold-off
	int hold_left;
	int style_left;
	int stall_style;
	int rx_beats;
	int rx_tick;
	bit long_hold_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
			style_left = 0;
			stall_style = 0;
			rx_beats = 0;
			rx_tick = 0;
			long_hold_done = 1'b0;
		end else begin
			rx_tick++;
			if (out_valid && out_ready)
				rx_beats++;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!long_hold_done && out_valid && rx_beats >= 12) begin
				long_hold_done = 1'b1;
				hold_left = 600;
				out_ready <= 1'b0;
			end else begin
				if (style_left == 0) begin
					stall_style = $urandom_range(0, 3);
					style_left = $urandom_range(20, 150);
				end else begin
					style_left--;
				end
				case (stall_style)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= (rx_tick % 4 == 0);
					default: begin
						out_ready <= ($urandom_range(0, 7) != 0);
						if ($urandom_range(0, 199) == 0)
							hold_left = $urandom_range(30, 120);
					end
				endcase
			end
		end
	end

	// checker
	scs_beat_t want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_scs.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected beat: char=%02h last=%0b none=%0b ovf=%0b",
						out_char, last_of_run, none, overflow);
			end else begin
				want = expected_scs.pop_front();
				if (out_char !== want.ch || last_of_run !== want.last ||
					none !== want.none || overflow !== want.ovf) begin
					errors++;
					if (errors <= 10)
						$display("beat differs: want char=%02h last=%0b none=%0b ovf=%0b, got char=%02h last=%0b none=%0b ovf=%0b",
							want.ch, want.last, want.none, want.ovf,
							out_char, last_of_run, none, overflow);
				end
			end
		end
	end

	task automatic push_beat(logic m, logic [CHAR_W-1:0] ch, logic has, logic eos);
		in_beat_t b;
		b = '{mode: m, ch: ch, has: has, eos: eos};
		pending_beats.insert(pending_beats.size(), b);
	endtask

	task automatic push_string(logic m, int len, int alpha);
		int base;
		bit extra_end;
		logic [CHAR_W-1:0] ch;
		base = $urandom_range(0, 255);
		extra_end = (len == 0) || ($urandom_range(0, 4) == 0);
		for (int i = 0; i < len; i++) begin
			if (alpha == 0)
				ch = CHAR_W'($urandom_range(0, 255));
			else
				ch = CHAR_W'(base + $urandom_range(0, alpha - 1));
			push_beat(m, ch, 1'b1, (i == len - 1) && !extra_end);
		end
		// drop the end of an empty first string now and then
		if (extra_end && !(m == MODE_FIRST && len == 0 && $urandom_range(0, 3) == 0))
			push_beat(m, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	function automatic int pick_len();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(9, 16);
		return $urandom_range(0, 8);
	endfunction

	function automatic int pick_alpha();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 2;
			2: return 3;
			default: return 4;
		endcase
	endfunction

	int set_idx;
	int full_at;
	int over_at;

	initial begin
		// both strings empty
		push_beat(MODE_FIRST, 8'h00, 1'b0, 1'b1);
		push_beat(MODE_SECOND, 8'h00, 1'b0, 1'b1);
		// second string only, all-ones byte
		push_beat(MODE_SECOND, 8'hFF, 1'b1, 1'b1);
		// equal zero bytes
		push_beat(MODE_FIRST, 8'h00, 1'b1, 1'b1);
		push_beat(MODE_SECOND, 8'h00, 1'b1, 1'b1);
		// match and mismatch
		push_beat(MODE_FIRST, 8'h00, 1'b1, 1'b0);
		push_beat(MODE_FIRST, 8'hAA, 1'b1, 1'b1);
		push_beat(MODE_SECOND, 8'hAA, 1'b1, 1'b0);
		push_beat(MODE_SECOND, 8'h55, 1'b1, 1'b1);
		// second string favored on the left
		push_beat(MODE_FIRST, 8'h41, 1'b1, 1'b1);
		push_beat(MODE_SECOND, 8'h42, 1'b1, 1'b0);
		push_beat(MODE_SECOND, 8'h41, 1'b1, 1'b1);
		// strings out of order, trigger without a byte
		push_beat(MODE_SECOND, 8'h12, 1'b1, 1'b0);
		push_beat(MODE_FIRST, 8'h34, 1'b1, 1'b0);
		push_beat(MODE_SECOND, 8'h12, 1'b1, 1'b0);
		push_beat(MODE_FIRST, 8'h12, 1'b1, 1'b0);
		push_beat(MODE_SECOND, 8'h00, 1'b0, 1'b1);
		// first empty, second without a byte end
		push_beat(MODE_SECOND, 8'hFF, 1'b0, 1'b1);

		full_at = $urandom_range(1, 3);
		over_at = $urandom_range(4, 6);
		set_idx = 0;
		while (pending_beats.size() < TARGET_BEATS || set_idx <= over_at) begin
			if (set_idx == full_at) begin
				push_string(MODE_FIRST, MAX_LEN, 2);
				push_string(MODE_SECOND, MAX_LEN, 2);
			end else if (set_idx == over_at) begin
				if ($urandom_range(0, 1)) begin
					push_string(MODE_FIRST, $urandom_range(MAX_LEN + 1, MAX_LEN + 4), 3);
					push_string(MODE_SECOND, pick_len(), 3);
				end else begin
					push_string(MODE_FIRST, pick_len(), 3);
					push_string(MODE_SECOND, $urandom_range(MAX_LEN + 1, MAX_LEN + 4), 3);
				end
			end else if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 4))
					push_beat(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
						1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
			end else begin
				push_string(MODE_FIRST, pick_len(), pick_alpha());
				push_string(MODE_SECOND, pick_len(), pick_alpha());
			end
			set_idx++;
		end
		push_string(MODE_FIRST, pick_len(), pick_alpha());
		push_string(MODE_SECOND, pick_len(), pick_alpha());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_beats.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_scs.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- files.f -----
sv/scs_pkg.sv
sv/scs_ram.sv
sv/scs_fill.sv
sv/shortest_common_supersequence_core.sv
test/shortest_common_supersequence_core_tb.sv
